// ===== design/itrt_pkg.sv =====
package itrt_pkg;

  localparam int MaxCapacity = 64;
  localparam int ValueBits   = 64;

  localparam int RadixW  = 5;
  localparam int CapW    = 7;
  localparam int CharW   = 7;
  localparam int LenW    = 6;
  localparam int DigitW  = 4;
  localparam int AddrW   = $clog2(MaxCapacity);

  // The divider retires this many quotient bits per cycle.
  localparam int StepBits = 8;
  localparam int DivSteps = (ValueBits + StepBits - 1) / StepBits;
  localparam int DivW     = DivSteps * StepBits;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  localparam logic [RadixW-1:0] RadixMin = 5'd2;
  localparam logic [RadixW-1:0] RadixMax = 5'd16;
  localparam logic [RadixW-1:0] RadixBin = 5'd2;
  localparam logic [RadixW-1:0] RadixHex = 5'd16;

  localparam logic [DigitW-1:0] DigitMaxDec = 4'd9;
  localparam logic [DigitW-1:0] DigitTen    = 4'd10;

  localparam logic [CharW-1:0] CharNul  = 7'h00;
  localparam logic [CharW-1:0] CharZero = 7'h30;
  localparam logic [CharW-1:0] CharB    = 7'h62;
  localparam logic [CharW-1:0] CharX    = 7'h78;
  localparam logic [CharW-1:0] CharLowA = 7'h61;
  localparam logic [CharW-1:0] CharUpA  = 7'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REJECT,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } itrt_state_e;

  function automatic logic [CharW-1:0] digit_char(logic [DigitW-1:0] d, logic lower);
    logic [CharW-1:0] ch;
    if (d <= DigitMaxDec) begin
      ch = CharZero + CharW'(d);
    end else begin
      ch = (lower ? CharLowA : CharUpA) + CharW'(d - DigitTen);
    end
    return ch;
  endfunction

endpackage

// ===== design/itrt_in_if.sv =====
interface itrt_in_if;
  logic                               valid;
  logic                               ready;
  logic [itrt_pkg::ValueBits-1:0]     value;
  logic [itrt_pkg::RadixW-1:0]        radix;
  logic [itrt_pkg::CapW-1:0]          capacity;
  logic                               with_prefix;
  logic                               lower_case;

  modport source (
    output valid, value, radix, capacity, with_prefix, lower_case,
    input  ready
  );
  modport sink (
    input  valid, value, radix, capacity, with_prefix, lower_case,
    output ready
  );
endinterface

// ===== design/itrt_out_if.sv =====
interface itrt_out_if;
  logic                           valid;
  logic                           ready;
  logic [itrt_pkg::CharW-1:0]     character;
  logic [itrt_pkg::LenW-1:0]      text_length;
  logic                           rejected;
  logic                           last;

  modport source (
    output valid, character, text_length, rejected, last,
    input  ready
  );
  modport sink (
    input  valid, character, text_length, rejected, last,
    output ready
  );
endinterface

// ===== design/itrt_ram.sv =====
module itrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/itrt_divider.sv =====
module itrt_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [itrt_pkg::ValueBits-1:0]    dividend_i,
  input  logic [itrt_pkg::RadixW-1:0]       divisor_i,
  output logic                              done_o,
  output logic [itrt_pkg::ValueBits-1:0]    quotient_o,
  output logic [itrt_pkg::DigitW-1:0]       remainder_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [itrt_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [itrt_pkg::DivW-1:0]          work_q, work_d;
  logic [itrt_pkg::DigitW-1:0]        rem_q, rem_d;
  logic [itrt_pkg::RadixW-1:0]        divisor_q, divisor_d;

  // Restoring division: the work register shifts the dividend out at the
  // top and the quotient bits in at the bottom, StepBits bits per cycle.
  always_comb begin
    logic [itrt_pkg::DigitW-1:0] r;
    logic [itrt_pkg::DivW-1:0]   w;
    logic [itrt_pkg::RadixW-1:0] t;
    r = rem_q;
    w = work_q;
    for (int i = 0; i < itrt_pkg::StepBits; i++) begin
      t = {r, w[itrt_pkg::DivW-1]};
      w = {w[itrt_pkg::DivW-2:0], 1'b0};
      if (t >= divisor_q) begin
        t    = t - divisor_q;
        w[0] = 1'b1;
      end
      r = t[itrt_pkg::DigitW-1:0];
    end

    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    work_d    = work_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = itrt_pkg::DivCntW'(itrt_pkg::DivSteps - 1);
      work_d    = itrt_pkg::DivW'(dividend_i);
      rem_d     = '0;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      work_d = w;
      rem_d  = r;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[itrt_pkg::ValueBits-1:0];
  assign remainder_o = rem_q;

endmodule

// ===== design/integer_to_radix_text.sv =====
// Unsigned integer to ASCII text in base 2 to 16.
// The input channel in_i takes one conversion request: value, radix,
// capacity (terminator included), with_prefix and lower_case. The output
// channel out_o returns the text one character per transfer, most
// significant digit first, then a NUL terminator with last set. Every
// transfer of a run carries the final text_length. A bad radix or a zero
// capacity gives one transfer with rejected and last set.
// Digits are produced low order first by an iterative divider that
// retires 8 quotient bits a cycle, and the digits wait in a small RAM
// until the length is known. Emission then runs one character per
// cycle while out_o is not stalled. in_i is ready only when no item is
// in work; the final character may still sit in the output register then.
// A stall on out_o holds the output register and pauses emission.
// Reset returns the sequencer to idle and drops out_o.valid.
module integer_to_radix_text (
  input  logic              clk_i,
  input  logic              rst_ni,
  itrt_in_if.sink           in_i,
  itrt_out_if.source        out_o
);

  itrt_pkg::itrt_state_e                state_q, state_d;
  logic [itrt_pkg::ValueBits-1:0]       val_q, val_d;
  logic [itrt_pkg::RadixW-1:0]          radix_q, radix_d;
  logic [itrt_pkg::CapW-1:0]            cap_q, cap_d;
  logic                                 pfx_q, pfx_d;
  logic                                 lower_q, lower_d;
  logic                                 zero_q, zero_d;
  logic [itrt_pkg::AddrW-1:0]           nd_q, nd_d;
  logic [itrt_pkg::AddrW-1:0]           dig_ptr_q, dig_ptr_d;
  logic [itrt_pkg::LenW-1:0]            len_q, len_d;
  logic [itrt_pkg::LenW-1:0]            ci_q, ci_d;

  logic                                 out_valid_q, out_valid_d;
  logic [itrt_pkg::CharW-1:0]           out_char_q, out_char_d;
  logic [itrt_pkg::LenW-1:0]            out_len_q, out_len_d;
  logic                                 out_rej_q, out_rej_d;
  logic                                 out_last_q, out_last_d;

  logic                                 div_start;
  logic                                 div_done;
  logic [itrt_pkg::ValueBits-1:0]       div_quo;
  logic [itrt_pkg::DigitW-1:0]          div_rem;
  logic                                 ram_we;
  logic [itrt_pkg::DigitW-1:0]          ram_rdata;

  logic                                 in_accept;
  logic                                 slot_free;
  logic [1:0]                           pfx_len;
  logic [itrt_pkg::CapW-1:0]            used_chars;

  assign in_accept = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign pfx_len   = {pfx_q, 1'b0};
  assign used_chars = itrt_pkg::CapW'(pfx_len) + itrt_pkg::CapW'(nd_q);

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    radix_d     = radix_q;
    cap_d       = cap_q;
    pfx_d       = pfx_q;
    lower_d     = lower_q;
    zero_d      = zero_q;
    nd_d        = nd_q;
    dig_ptr_d   = dig_ptr_q;
    len_d       = len_q;
    ci_d        = ci_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_len_d   = out_len_q;
    out_rej_d   = out_rej_q;
    out_last_d  = out_last_q;
    div_start   = 1'b0;
    ram_we      = 1'b0;

    case (state_q)
      itrt_pkg::ST_IDLE: begin
        if (in_accept) begin
          val_d   = in_i.value;
          radix_d = in_i.radix;
          cap_d   = (in_i.capacity > itrt_pkg::CapW'(itrt_pkg::MaxCapacity)) ?
                    itrt_pkg::CapW'(itrt_pkg::MaxCapacity) : in_i.capacity;
          pfx_d   = in_i.with_prefix &&
                    (in_i.radix == itrt_pkg::RadixBin || in_i.radix == itrt_pkg::RadixHex);
          lower_d = in_i.lower_case;
          // A zero value always gives one '0' digit, without division.
          zero_d  = (in_i.value == '0);
          nd_d    = (in_i.value == '0) ? itrt_pkg::AddrW'(1) : '0;
          if (!(in_i.radix inside {[itrt_pkg::RadixMin:itrt_pkg::RadixMax]}) ||
              in_i.capacity == '0) begin
            state_d = itrt_pkg::ST_REJECT;
          end else begin
            state_d = itrt_pkg::ST_CHECK;
          end
        end
      end

      itrt_pkg::ST_REJECT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itrt_pkg::CharNul;
          out_len_d   = '0;
          out_rej_d   = 1'b1;
          out_last_d  = 1'b1;
          state_d     = itrt_pkg::ST_IDLE;
        end
      end

      itrt_pkg::ST_CHECK: begin
        if (!zero_q && val_q != '0 && (used_chars + 1'b1) < cap_q) begin
          div_start = 1'b1;
          state_d   = itrt_pkg::ST_DIV;
        end else begin
          len_d     = itrt_pkg::LenW'(used_chars);
          dig_ptr_d = nd_q - 1'b1;
          ci_d      = '0;
          state_d   = itrt_pkg::ST_EMIT;
        end
      end

      itrt_pkg::ST_DIV: begin
        if (div_done) begin
          ram_we  = 1'b1;
          val_d   = div_quo;
          nd_d    = nd_q + 1'b1;
          state_d = itrt_pkg::ST_CHECK;
        end
      end

      itrt_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_len_d   = len_q;
          out_rej_d   = 1'b0;
          out_last_d  = 1'b0;
          ci_d        = ci_q + 1'b1;
          if (ci_q < itrt_pkg::LenW'(pfx_len)) begin
            if (ci_q == '0) begin
              out_char_d = itrt_pkg::CharZero;
            end else begin
              out_char_d = (radix_q == itrt_pkg::RadixBin) ? itrt_pkg::CharB : itrt_pkg::CharX;
            end
          end else if (ci_q < len_q) begin
            out_char_d = zero_q ? itrt_pkg::CharZero : itrt_pkg::digit_char(ram_rdata, lower_q);
            dig_ptr_d  = dig_ptr_q - 1'b1;
          end else begin
            out_char_d = itrt_pkg::CharNul;
            out_last_d = 1'b1;
            state_d    = itrt_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = itrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itrt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      radix_q     <= '0;
      cap_q       <= '0;
      pfx_q       <= 1'b0;
      lower_q     <= 1'b0;
      zero_q      <= 1'b0;
      nd_q        <= '0;
      dig_ptr_q   <= '0;
      len_q       <= '0;
      ci_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      radix_q     <= radix_d;
      cap_q       <= cap_d;
      pfx_q       <= pfx_d;
      lower_q     <= lower_d;
      zero_q      <= zero_d;
      nd_q        <= nd_d;
      dig_ptr_q   <= dig_ptr_d;
      len_q       <= len_d;
      ci_q        <= ci_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    out_char_q <= out_char_d;
    out_len_q  <= out_len_d;
    out_rej_q  <= out_rej_d;
    out_last_q <= out_last_d;
  end

  itrt_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (val_q),
    .divisor_i   (radix_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // The read address follows the next digit pointer, so the registered
  // read data always holds the digit that the pointer names.
  itrt_ram #(
    .Width (itrt_pkg::DigitW),
    .Depth (itrt_pkg::MaxCapacity)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (nd_q),
    .wdata_i (div_rem),
    .raddr_i (dig_ptr_d),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready        = (state_q == itrt_pkg::ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.character   = out_char_q;
  assign out_o.text_length = out_len_q;
  assign out_o.rejected    = out_rej_q;
  assign out_o.last        = out_last_q;

endmodule

// ===== verif/tb_integer_to_radix_text.sv =====
module tb_integer_to_radix_text;
  import itrt_pkg::*;

  localparam int NumRandom  = 410;
  localparam int HoldAfter  = 40;
  localparam int HoldCycles = 2000;
  localparam int DrainWait  = 80;
  localparam int CycleLimit = 3_000_000;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [RadixW-1:0]    radix;
    logic [CapW-1:0]      capacity;
    logic                 with_prefix;
    logic                 lower_case;
  } conv_req_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic [LenW-1:0]  text_length;
    logic             rejected;
    logic             last;
  } text_beat_t;

  class text_checker;
    text_beat_t expected_chars[$];
    int         errors;
    int         accepted;

    // Renders the whole text of one request, terminator included.
    function void note_request(conv_req_t r);
      longint unsigned  v;
      int unsigned      base;
      int unsigned      cap;
      logic [3:0]       d;
      logic [CharW-1:0] text[$];
      logic [CharW-1:0] digs[$];
      logic [LenW-1:0]  len;
      accepted++;
      if (r.radix < RadixMin || r.radix > RadixMax || r.capacity == '0) begin
        expected_chars.push_back('{CharNul, '0, 1'b1, 1'b1});
        return;
      end
      v    = r.value;
      base = r.radix;
      cap  = r.capacity;
      if (cap > MaxCapacity) cap = MaxCapacity;
      if (r.with_prefix && (r.radix == RadixBin || r.radix == RadixHex)) begin
        text.push_back(CharZero);
        text.push_back(r.radix == RadixBin ? CharB : CharX);
      end
      if (v == 0) begin
        text.push_back(CharZero);
      end else begin
        // Digits come out low order first; only the ones that fit are kept.
        while (v != 0 && text.size() + digs.size() + 1 < cap) begin
          d = 4'(v % base);
          if (d <= 4'd9) begin
            digs.push_front(CharZero + CharW'(d));
          end else begin
            digs.push_front((r.lower_case ? CharLowA : CharUpA) + CharW'(d - 4'd10));
          end
          v = v / base;
        end
      end
      text = {text, digs};
      len  = LenW'(text.size());
      foreach (text[i]) expected_chars.push_back('{text[i], len, 1'b0, 1'b0});
      expected_chars.push_back('{CharNul, len, 1'b0, 1'b1});
    endfunction

    task report(string field, int got, int want);
      errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    endtask

    task check_beat(text_beat_t got);
      text_beat_t want;
      if (expected_chars.size() == 0) begin
        report("unexpected transfer, character", got.character, -1);
        return;
      end
      want = expected_chars.pop_front();
      if (got.character != want.character) report("character", got.character, want.character);
      if (got.text_length != want.text_length)
        report("text_length", got.text_length, want.text_length);
      if (got.rejected != want.rejected) report("rejected", got.rejected, want.rejected);
      if (got.last != want.last) report("last", got.last, want.last);
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycle_count = 0;
  bit   hold_done = 1'b0;

  itrt_in_if  in_if ();
  itrt_out_if out_if ();

  text_checker sb = new();

  integer_to_radix_text uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[integer_to_radix_text] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_beat('{out_if.character, out_if.text_length, out_if.rejected, out_if.last});
    end
  end

  // Entered and left at a falling edge; returns once the transfer is taken.
  task automatic offer(input conv_req_t r);
    in_if.valid       = 1'b1;
    in_if.value       = r.value;
    in_if.radix       = r.radix;
    in_if.capacity    = r.capacity;
    in_if.with_prefix = r.with_prefix;
    in_if.lower_case  = r.lower_case;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic offer_fields(input logic [ValueBits-1:0] v, input int radix, input int cap,
                              input bit pfx, input bit lower);
    offer('{v, RadixW'(radix), CapW'(cap), pfx, lower});
  endtask

  function automatic conv_req_t random_request();
    conv_req_t   r;
    int unsigned nbits;
    int unsigned pick;
    nbits   = $urandom_range(0, 64);
    r.value = {$urandom, $urandom};
    if (nbits < 64) r.value &= (64'd1 << nbits) - 64'd1;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.radix = RadixW'($urandom_range(0, 31));
    end else if (pick < 40) begin
      r.radix = ($urandom_range(0, 1) != 0) ? RadixBin : RadixHex;
    end else begin
      r.radix = RadixW'($urandom_range(2, 16));
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.capacity = '0;
    end else if (pick < 70) begin
      r.capacity = CapW'($urandom_range(1, 16));
    end else if (pick < 90) begin
      r.capacity = CapW'($urandom_range(17, 64));
    end else begin
      r.capacity = CapW'($urandom_range(65, 127));
    end
    r.with_prefix = 1'($urandom_range(0, 1));
    r.lower_case  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Receiver: changing stall patterns, plus one long hold-off that backs the
  // block up while the sender keeps offering.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && sb.accepted >= HoldAfter) begin
        @(negedge clk_i);
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      mode   = $urandom_range(0, 2);
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 7);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          0: begin
            out_if.ready = 1'b1;
          end
          1: begin
            out_if.ready = ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_if.ready = ((k % period) != 0);
          end
        endcase
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent              = 0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.value       = '0;
    in_if.radix       = '0;
    in_if.capacity    = '0;
    in_if.with_prefix = 1'b0;
    in_if.lower_case  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero value, and prefix plus zero digit written past a capacity of one.
    offer_fields('0, 10, 10, 1'b0, 1'b0);
    offer_fields('0, 2, 1, 1'b1, 1'b0);
    offer_fields('0, 16, 1, 1'b1, 1'b1);
    // Full-scale values, both cases, capacity saturation above the maximum.
    offer_fields('1, 16, 64, 1'b0, 1'b0);
    offer_fields('1, 16, 64, 1'b1, 1'b1);
    offer_fields('1, 2, 64, 1'b0, 1'b0);
    offer_fields('1, 2, 127, 1'b1, 1'b0);
    offer_fields('1, 10, 21, 1'b0, 1'b0);
    // Truncation keeps the low-order digits; a capacity of one keeps none.
    offer_fields(64'hFEDC_BA98_7654_3210, 16, 5, 1'b0, 1'b1);
    offer_fields(64'd12345, 10, 2, 1'b0, 1'b0);
    offer_fields(64'd12345, 10, 1, 1'b0, 1'b0);
    offer_fields(64'd1, 2, 3, 1'b1, 1'b0);
    // Prefix is ignored outside base 2 and 16.
    offer_fields(64'd1000, 3, 20, 1'b1, 1'b0);
    offer_fields(64'd4095, 8, 20, 1'b1, 1'b1);
    offer_fields(64'hABCD, 15, 20, 1'b1, 1'b1);
    // Rejected requests: bad radix or zero capacity.
    offer_fields(64'd7, 0, 10, 1'b0, 1'b0);
    offer_fields(64'd7, 1, 10, 1'b1, 1'b0);
    offer_fields(64'd7, 17, 10, 1'b0, 1'b1);
    offer_fields('1, 31, 127, 1'b1, 1'b1);
    offer_fields(64'd7, 10, 0, 1'b0, 1'b0);

    while (sent < NumRandom) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < NumRandom; k++) begin
        offer(random_request());
        sent++;
      end
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_if.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[integer_to_radix_text] OK");
    end else begin
      $display("[integer_to_radix_text] ERROR");
    end
    $finish;
  end

endmodule
